// ----- sv/stsg_pkg.sv -----
// Shared constants, types and the sine table builder of the sine tone sweep generator.
`default_nettype none

package stsg_pkg;

   localparam int PHASE_BITS      = 32;
   localparam int SINE_TABLE_BITS = 10;
   localparam int SINE_WIDTH      = 24;
   localparam int MAX_CHANNELS    = 8;

   localparam int TABLE_SIZE    = 1 << SINE_TABLE_BITS;
   localparam int OPERAND_BITS  = (PHASE_BITS > 32) ? PHASE_BITS : 32;
   localparam int PRODUCT_BITS  = 2 * OPERAND_BITS;
   localparam int COUNT_BITS    = $clog2(PRODUCT_BITS);
   localparam int CHANNEL_BITS  = 3;
   localparam int CHAN_CFG_BITS = 4;
   localparam int STEP_CFG_BITS = 31;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CHANNEL_LIMIT = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;

   localparam logic [63:0] SINE_PEAK   = (64'd1 << (SINE_WIDTH - 1)) - 64'd1;
   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [5:0][7:0] SERIES_DIV = {8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};

   localparam int GAIN_SHIFT  = 15;
   localparam int SWEEP_SHIFT = 30;
   localparam logic [OPERAND_BITS-1:0] GAIN_ROUND  = OPERAND_BITS'(1 << (GAIN_SHIFT - 1));
   localparam logic [OPERAND_BITS-1:0] SWEEP_ROUND = OPERAND_BITS'(1 << (SWEEP_SHIFT - 1));
   localparam logic [OPERAND_BITS-1:0] DIV_ROUND   = OPERAND_BITS'(SINE_PEAK >> 1);

   localparam logic [CSR_INDEX_BITS-1:0] CFG_PHASE_STEP      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CFG_AMPLITUDE_GAIN  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CFG_RESOLUTION_MODE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CFG_CHANNEL_COUNT   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CFG_SWEEP_ENABLE    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CFG_SWEEP_RATIO     = 3'd5;

   localparam logic [1:0] RES_16 = 2'd0;
   localparam logic [1:0] RES_24 = 2'd1;
   localparam logic [1:0] RES_32 = 2'd2;

   localparam logic OP_MUL = 1'b0;
   localparam logic OP_DIV = 1'b1;

   typedef struct packed {
      logic start;
      logic op;
   } stsg_cmd_type;

   typedef logic [TABLE_SIZE-1:0][SINE_WIDTH-1:0] sine_rom_type;

   // Quarter-wave table, sampled at the middle of each step and built with
   // a fixed Q30 Taylor series so that every entry matches bit for bit.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  t;
      logic [63:0]  s;
      logic [63:0]  v;
      int           i;
      int           k;
      for (i = 0; i < TABLE_SIZE; i++) begin
         x  = (HALF_PI_Q30 * 64'(2 * i + 1)) >> (SINE_TABLE_BITS + 1);
         x2 = (x * x + (Q30_ONE >> 1)) >> 30;
         t  = Q30_ONE;
         for (k = 0; k < 6; k++) begin
            t = Q30_ONE - (((x2 * t) >> 30) / 64'(SERIES_DIV[k]));
         end
         s = (x * t) >> 30;
         v = (s * SINE_PEAK + (Q30_ONE >> 1)) >> 30;
         if (v > SINE_PEAK) begin
            v = SINE_PEAK;
         end
         rom[i] = v[SINE_WIDTH-1:0];
      end
      return rom;
   endfunction

endpackage

`default_nettype wire

// ----- sv/stsg_serial_unit.sv -----
// Bit-serial multiply-add and divide-by-table-peak unit of the sine tone sweep generator.
`default_nettype none

module stsg_serial_unit import stsg_pkg::*; (
   input  wire                     clock,
   input  wire                     reset,
   input  wire stsg_cmd_type       cmd,
   input  wire [OPERAND_BITS-1:0]  op_a,
   input  wire [OPERAND_BITS-1:0]  op_b,
   input  wire [OPERAND_BITS-1:0]  op_c,
   output logic                    busy,
   output logic [PRODUCT_BITS-1:0] product
);

   logic [OPERAND_BITS-1:0] a_ff;
   logic [OPERAND_BITS-1:0] b_ff;
   logic [OPERAND_BITS-1:0] hi_ff;
   logic [OPERAND_BITS-1:0] lo_ff;
   logic [SINE_WIDTH-2:0]   rem_ff;
   logic [COUNT_BITS-1:0]   cnt_ff;
   logic                    busy_ff;
   logic                    op_ff;

   logic [OPERAND_BITS:0]   sum;
   logic [SINE_WIDTH-1:0]   trial;
   logic                    trial_ge;
   logic [SINE_WIDTH-1:0]   trial_diff;
   logic                    step_last;

   // One multiplier bit per cycle, least significant first; the product
   // shifts right through hi and lo. The addend preloads hi.
   assign sum = {1'b0, hi_ff} + (b_ff[0] ? {1'b0, a_ff} : '0);

   // Restoring division by the table peak, one quotient bit per cycle.
   assign trial      = {rem_ff, hi_ff[OPERAND_BITS-1]};
   assign trial_ge   = trial >= SINE_WIDTH'(SINE_PEAK);
   assign trial_diff = trial - SINE_WIDTH'(SINE_PEAK);

   assign step_last = (op_ff == OP_DIV) ? (cnt_ff == COUNT_BITS'(PRODUCT_BITS - 1))
                                        : (cnt_ff == COUNT_BITS'(OPERAND_BITS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= OP_MUL;
      end else if (cmd.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         op_ff   <= cmd.op;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + COUNT_BITS'(1);
         if (step_last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         if (cmd.op == OP_MUL) begin
            a_ff  <= op_a;
            b_ff  <= op_b;
            hi_ff <= op_c;
            lo_ff <= '0;
         end else begin
            rem_ff <= '0;
         end
      end else if (busy_ff) begin
         if (op_ff == OP_MUL) begin
            hi_ff <= sum[OPERAND_BITS:1];
            lo_ff <= {sum[0], lo_ff[OPERAND_BITS-1:1]};
            b_ff  <= {1'b0, b_ff[OPERAND_BITS-1:1]};
         end else begin
            rem_ff <= trial_ge ? trial_diff[SINE_WIDTH-2:0] : trial[SINE_WIDTH-2:0];
            hi_ff  <= {hi_ff[OPERAND_BITS-2:0], lo_ff[OPERAND_BITS-1]};
            lo_ff  <= {lo_ff[OPERAND_BITS-2:0], trial_ge};
         end
      end
   end

   assign busy    = busy_ff;
   assign product = {hi_ff, lo_ff};

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) cmd.start |-> !busy_ff)
      else $error("A new operation started while the unit was busy.");

   assert property (@(posedge clock) disable iff (reset) $fell(busy_ff) |-> $past(step_last))
      else $error("The unit finished before its last step.");

   assert property (@(posedge clock) disable iff (reset)
      busy_ff && (op_ff == OP_DIV) |-> rem_ff < (SINE_WIDTH - 1)'(SINE_PEAK))
      else $error("The division remainder reached the divisor.");
`endif

endmodule

`default_nettype wire

// ----- sv/sine_tone_sweep_generator.sv -----
// Top level of the direct digital synthesis sine tone generator with exponential sweep.
// Each frame request with its bit set reads the quarter-wave sine table at the phase
// accumulator, scales the value by the amplitude gain and to the full scale of the chosen
// resolution, and emits the saturated sample once per channel, marking the last one. A
// request with its bit clear is taken and does nothing. The multiplications and the division
// go through one bit-serial unit that handles one multiplier bit or one quotient bit per
// cycle: two 32-step multiplications and a 64-step division by the table peak come before
// the first sample is put on the result port, the channel samples then follow one per cycle
// while the receiver takes them, and a sweep adds a step multiplication at the end of the
// frame. The next request is taken once the frame is done. Registers are written only
// between frames.
`default_nettype none

module sine_tone_sweep_generator import stsg_pkg::*; (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire                       req_frame_request,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output logic signed [31:0]        rsp_sample_value,
   output logic [CHANNEL_BITS-1:0]   rsp_channel_index,
   output logic                      rsp_last_of_frame,
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  wire [CSR_INDEX_BITS-1:0]  csr_index,
   input  wire [31:0]                csr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ROM   = 3'd1;
   localparam logic [2:0] ST_GAIN  = 3'd2;
   localparam logic [2:0] ST_SCALE = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;
   localparam logic [2:0] ST_SWEEP = 3'd6;

   localparam sine_rom_type SineRom = build_sine_rom();

   logic [2:0]                state_ff;
   logic [PHASE_BITS-1:0]     phase_ff;
   logic [PHASE_BITS-1:0]     step_ff;
   logic [15:0]               gain_ff;
   logic [1:0]                res_ff;
   logic [CHAN_CFG_BITS-1:0]  chan_ff;
   logic                      sweep_en_ff;
   logic [31:0]               ratio_ff;
   logic [SINE_WIDTH-1:0]     rom_q_ff;
   logic                      sign_ff;
   logic [31:0]               word_ff;
   logic [CHANNEL_BITS-1:0]   ch_ff;
   logic                      rsp_valid_ff;
   logic [31:0]               rsp_value_ff;
   logic [CHANNEL_BITS-1:0]   rsp_index_ff;
   logic                      rsp_last_ff;

   stsg_cmd_type              unit_cmd;
   logic [OPERAND_BITS-1:0]   unit_a;
   logic [OPERAND_BITS-1:0]   unit_b;
   logic [OPERAND_BITS-1:0]   unit_c;
   logic                      unit_busy;
   logic [PRODUCT_BITS-1:0]   unit_product;

   logic [1:0]                quadrant;
   logic [SINE_TABLE_BITS-1:0] idx_raw;
   logic [SINE_TABLE_BITS-1:0] rom_idx;
   logic [CHAN_CFG_BITS-1:0]  n_eff;
   logic                      ch_last;
   logic                      out_load;
   logic                      csr_write;
   logic [31:0]               fs_word;
   logic [31:0]               lim_word;
   logic                      over_pos;
   logic                      over_neg;
   logic [31:0]               sat_word;
   logic                      sweep_over;
   logic [PHASE_BITS-1:0]     sweep_step;

   stsg_serial_unit u_unit (
      .clock   (clock),
      .reset   (reset),
      .cmd     (unit_cmd),
      .op_a    (unit_a),
      .op_b    (unit_b),
      .op_c    (unit_c),
      .busy    (unit_busy),
      .product (unit_product)
   );

   assign quadrant = phase_ff[PHASE_BITS-1 -: 2];
   assign idx_raw  = phase_ff[PHASE_BITS-3 -: SINE_TABLE_BITS];
   assign rom_idx  = quadrant[0] ? ~idx_raw : idx_raw;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      if (chan_ff == '0) begin
         n_eff = CHAN_CFG_BITS'(1);
      end else if (chan_ff > CHAN_CFG_BITS'(CHANNEL_LIMIT)) begin
         n_eff = CHAN_CFG_BITS'(CHANNEL_LIMIT);
      end else begin
         n_eff = chan_ff;
      end
   end

   assign ch_last  = (CHAN_CFG_BITS'(ch_ff) + CHAN_CFG_BITS'(1)) == n_eff;
   assign out_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      case (res_ff)
         RES_16: begin
            fs_word  = 32'h0000_7FFF;
            lim_word = 32'h0000_8000;
            over_pos = |unit_product[PRODUCT_BITS-1:15];
            over_neg = (|unit_product[PRODUCT_BITS-1:16])
                       | (unit_product[15] & (|unit_product[14:0]));
         end
         RES_24: begin
            fs_word  = 32'h007F_FFFF;
            lim_word = 32'h0080_0000;
            over_pos = |unit_product[PRODUCT_BITS-1:23];
            over_neg = (|unit_product[PRODUCT_BITS-1:24])
                       | (unit_product[23] & (|unit_product[22:0]));
         end
         default: begin
            fs_word  = 32'h7FFF_FFFF;
            lim_word = 32'h8000_0000;
            over_pos = |unit_product[PRODUCT_BITS-1:31];
            over_neg = (|unit_product[PRODUCT_BITS-1:32])
                       | (unit_product[31] & (|unit_product[30:0]));
         end
      endcase
   end

   always_comb begin
      if (sign_ff) begin
         sat_word = over_neg ? (32'd0 - lim_word) : (32'd0 - unit_product[31:0]);
      end else begin
         sat_word = over_pos ? fs_word : unit_product[31:0];
      end
   end

   assign sweep_over = |unit_product[PRODUCT_BITS-1:SWEEP_SHIFT+PHASE_BITS];
   assign sweep_step = sweep_over ? '1 : unit_product[SWEEP_SHIFT +: PHASE_BITS];

   always_comb begin
      unit_cmd = '0;
      unit_a   = '0;
      unit_b   = '0;
      unit_c   = '0;
      unique case (state_ff)
         ST_ROM: begin
            unit_cmd.start = 1'b1;
            unit_cmd.op    = OP_MUL;
            unit_a         = OPERAND_BITS'(rom_q_ff);
            unit_b         = OPERAND_BITS'(gain_ff);
            unit_c         = GAIN_ROUND;
         end
         ST_GAIN: begin
            if (!unit_busy) begin
               unit_cmd.start = 1'b1;
               unit_cmd.op    = OP_MUL;
               unit_a         = OPERAND_BITS'(fs_word);
               unit_b         = unit_product[GAIN_SHIFT +: OPERAND_BITS];
               unit_c         = DIV_ROUND;
            end
         end
         ST_SCALE: begin
            if (!unit_busy) begin
               unit_cmd.start = 1'b1;
               unit_cmd.op    = OP_DIV;
            end
         end
         ST_EMIT: begin
            if (out_load && ch_last && sweep_en_ff) begin
               unit_cmd.start = 1'b1;
               unit_cmd.op    = OP_MUL;
               unit_a         = OPERAND_BITS'(step_ff);
               unit_b         = OPERAND_BITS'(ratio_ff);
               unit_c         = SWEEP_ROUND;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= '0;
         step_ff  <= '0;
         ch_ff    <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_frame_request) begin
                  phase_ff <= phase_ff + step_ff;
                  state_ff <= ST_ROM;
               end
               if (csr_write && (csr_index == CFG_PHASE_STEP)) begin
                  step_ff <= PHASE_BITS'(csr_data[STEP_CFG_BITS-1:0]);
               end
            end
            ST_ROM: begin
               state_ff <= ST_GAIN;
            end
            ST_GAIN: begin
               if (!unit_busy) begin
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               if (!unit_busy) begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (!unit_busy) begin
                  ch_ff    <= '0;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_load) begin
                  ch_ff <= ch_ff + CHANNEL_BITS'(1);
                  if (ch_last) begin
                     state_ff <= sweep_en_ff ? ST_SWEEP : ST_IDLE;
                  end
               end
            end
            ST_SWEEP: begin
               if (!unit_busy) begin
                  step_ff  <= sweep_step;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_valid && req_frame_request) begin
         rom_q_ff <= SineRom[rom_idx];
         sign_ff  <= quadrant[1];
      end
      if ((state_ff == ST_DIV) && !unit_busy) begin
         word_ff <= sat_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff     <= 16'd32768;
         res_ff      <= RES_16;
         chan_ff     <= CHAN_CFG_BITS'(2);
         sweep_en_ff <= 1'b0;
         ratio_ff    <= 32'h4000_0000;
      end else if (csr_write) begin
         unique case (csr_index)
            CFG_AMPLITUDE_GAIN:  gain_ff     <= csr_data[15:0];
            CFG_RESOLUTION_MODE: res_ff      <= csr_data[1:0];
            CFG_CHANNEL_COUNT:   chan_ff     <= csr_data[CHAN_CFG_BITS-1:0];
            CFG_SWEEP_ENABLE:    sweep_en_ff <= csr_data[0];
            CFG_SWEEP_RATIO:     ratio_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_value_ff <= word_ff;
         rsp_index_ff <= ch_ff;
         rsp_last_ff  <= ch_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_value  = rsp_value_ff;
   assign rsp_channel_index = rsp_index_ff;
   assign rsp_last_of_frame = rsp_last_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("A result transfer was offered outside the emit phase.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (CHAN_CFG_BITS'(ch_ff) < n_eff))
      else $error("The channel counter ran past the channel count.");

   assert property (@(posedge clock) disable iff (reset)
      !(req_valid && !req_stall && req_frame_request) |=> $stable(phase_ff))
      else $error("The phase moved without a frame request.");
`endif

endmodule

`default_nettype wire

// ----- verif/tone_frame_checker.sv -----
// Checker that predicts every sample frame of the tone generator and compares each transfer.
`default_nettype none

module tone_frame_checker import stsg_pkg::*; (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   input  wire                      req_stall,
   input  wire                      req_frame_request,
   input  wire                      rsp_valid,
   input  wire                      rsp_stall,
   input  wire signed [31:0]        rsp_sample_value,
   input  wire [CHANNEL_BITS-1:0]   rsp_channel_index,
   input  wire                      rsp_last_of_frame,
   input  wire                      csr_valid,
   input  wire                      csr_ready,
   input  wire [CSR_INDEX_BITS-1:0] csr_index,
   input  wire [31:0]               csr_data,
   output int                       error_count,
   output int                       expected_left
);

   localparam logic [63:0]      LUT_PEAK     = (64'd1 << 23) - 64'd1;
   localparam logic [63:0]      Q30_UNIT     = 64'd1 << 30;
   localparam logic [63:0]      QUARTER_TURN = 64'd1686629713;
   localparam logic [5:0][7:0]  TAYLOR_DIV   = {8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};

   typedef struct packed {
      logic signed [31:0]      value;
      logic [CHANNEL_BITS-1:0] chan;
      logic                    last;
   } channel_sample_type;

   logic [23:0]        quarter_sine [0:1023];
   channel_sample_type expected_samples [$];
   channel_sample_type observed;

   logic [31:0] tone_phase;
   logic [31:0] tone_step;
   logic [15:0] gain;
   logic [1:0]  res_mode;
   logic [3:0]  chan_cfg;
   logic        sweep_on;
   logic [31:0] sweep_mult;

   initial begin : build_quarter_sine
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      for (int i = 0; i < 1024; i++) begin
         x  = (QUARTER_TURN * 64'(2 * i + 1)) >> 11;
         x2 = (x * x + (Q30_UNIT >> 1)) >> 30;
         t  = Q30_UNIT;
         for (int k = 0; k < 6; k++) begin
            t = Q30_UNIT - (((x2 * t) >> 30) / 64'(TAYLOR_DIV[k]));
         end
         s = (x * t) >> 30;
         v = (s * LUT_PEAK + (Q30_UNIT >> 1)) >> 30;
         if (v > LUT_PEAK) begin
            v = LUT_PEAK;
         end
         quarter_sine[i] = v[23:0];
      end
   end

   task automatic synthesize_frame();
      logic [1:0]         quadrant;
      logic [9:0]         lut_addr;
      logic [63:0]        mag;
      logic [63:0]        full;
      logic [63:0]        level;
      logic [63:0]        part_hi;
      logic [63:0]        part_lo;
      logic [63:0]        next_step;
      logic [31:0]        word;
      int                 count;
      channel_sample_type item;
      quadrant = tone_phase[31:30];
      lut_addr = tone_phase[29:20];
      if (quadrant[0]) begin
         lut_addr = 10'd1023 - lut_addr;
      end
      case (res_mode)
         RES_16: begin
            full = 64'd32767;
         end
         RES_24: begin
            full = 64'h7F_FFFF;
         end
         default: begin
            full = 64'h7FFF_FFFF;
         end
      endcase
      mag   = (64'(quarter_sine[lut_addr]) * 64'(gain) + 64'd16384) >> 15;
      level = (mag * full + (LUT_PEAK >> 1)) / LUT_PEAK;
      if (quadrant[1]) begin
         if (level > full + 64'd1) begin
            level = full + 64'd1;
         end
         word = 32'd0 - level[31:0];
      end else begin
         if (level > full) begin
            level = full;
         end
         word = level[31:0];
      end
      count = (chan_cfg == 4'd0) ? 1 : (int'(chan_cfg) > CHANNEL_LIMIT) ? CHANNEL_LIMIT
                                                                         : int'(chan_cfg);
      for (int ch = 0; ch < count; ch++) begin
         item.value = word;
         item.chan  = CHANNEL_BITS'(ch);
         item.last  = (ch == count - 1);
         expected_samples.push_back(item);
      end
      tone_phase = tone_phase + tone_step;
      if (sweep_on) begin
         part_hi   = 64'(tone_step) * 64'(sweep_mult[31:16]);
         part_lo   = 64'(tone_step) * 64'(sweep_mult[15:0]);
         next_step = (part_hi >> 14)
                   + ((part_lo + ((part_hi & 64'h3FFF) << 16) + (Q30_UNIT >> 1)) >> 30);
         tone_step = (next_step > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : next_step[31:0];
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tone_phase  = 32'd0;
         tone_step   = 32'd0;
         gain        = 16'd32768;
         res_mode    = RES_16;
         chan_cfg    = 4'd2;
         sweep_on    = 1'b0;
         sweep_mult  = 32'h4000_0000;
         error_count = 0;
         expected_samples.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               if (error_count < 10) begin
                  $display("unexpected sample %0d on channel %0d", rsp_sample_value,
                           rsp_channel_index);
               end
               error_count++;
            end else begin
               observed = expected_samples.pop_front();
               if (observed.value !== rsp_sample_value || observed.chan !== rsp_channel_index
                   || observed.last !== rsp_last_of_frame) begin
                  if (error_count < 10) begin
                     $display("mismatch: expected %0d ch %0d last %0d, got %0d ch %0d last %0d",
                              observed.value, observed.chan, observed.last,
                              rsp_sample_value, rsp_channel_index, rsp_last_of_frame);
                  end
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CFG_PHASE_STEP: begin
                  tone_step = {1'b0, csr_data[30:0]};
               end
               CFG_AMPLITUDE_GAIN: begin
                  gain = csr_data[15:0];
               end
               CFG_RESOLUTION_MODE: begin
                  res_mode = csr_data[1:0];
               end
               CFG_CHANNEL_COUNT: begin
                  chan_cfg = csr_data[3:0];
               end
               CFG_SWEEP_ENABLE: begin
                  sweep_on = csr_data[0];
               end
               CFG_SWEEP_RATIO: begin
                  sweep_mult = csr_data;
               end
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall && req_frame_request) begin
            synthesize_frame();
         end
      end
      expected_left = expected_samples.size();
   end

endmodule

`default_nettype wire

// ----- verif/tb_sine_tone_sweep_generator.sv -----
// Testbench top that drives configuration, frame requests and result stalls and gives the verdict.
`default_nettype none

module tb_sine_tone_sweep_generator import stsg_pkg::*; ();

   localparam logic [1:0]                RES_UNUSED     = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CFG_SPARE_LOW  = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CFG_SPARE_HIGH = 3'd7;
   localparam logic [31:0]               RATIO_UNITY    = 32'h4000_0000;
   localparam logic [31:0]               GAIN_UNITY     = 32'd32768;
   localparam int SETTLE_CYCLES  = 60;
   localparam int DRAIN_CYCLES   = 250;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_FRAMES  = 240;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_frame_request = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [31:0]        rsp_sample_value;
   logic [CHANNEL_BITS-1:0]   rsp_channel_index;
   logic                      rsp_last_of_frame;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [31:0]               csr_data = '0;

   int error_count;
   int expected_left;
   int quiet_cycles = 0;
   int req_gap_max = 10;
   int rsp_gap_max = 10;
   int rsp_hold_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sine_tone_sweep_generator u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_frame_request (req_frame_request),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample_value  (rsp_sample_value),
      .rsp_channel_index (rsp_channel_index),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   tone_frame_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_frame_request (req_frame_request),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample_value  (rsp_sample_value),
      .rsp_channel_index (rsp_channel_index),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .error_count       (error_count),
      .expected_left     (expected_left)
   );

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_sine_tone_sweep_generator NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : result_side
      int gap;
      forever begin
         if (rsp_hold_cycles != 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            gap = $urandom_range(0, rsp_gap_max);
         end
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_frame(input logic frame_bit);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_frame_request <= frame_bit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_left != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic shuffle_settings(input logic write_all);
      logic [31:0] value;
      if (write_all || $urandom_range(0, 1) == 0) begin
         case ($urandom_range(0, 5))
            0: value = 32'd0;
            1: value = 32'hFFFF_FFFF;
            2: value = $urandom;
            default: value = $urandom_range(1, 32'h0100_0000);
         endcase
         write_reg(CFG_PHASE_STEP, value);
      end
      if (write_all || $urandom_range(0, 1) == 0) begin
         case ($urandom_range(0, 5))
            0: value = 32'd0;
            1: value = 32'd65535;
            2: value = $urandom_range(32768, 65535);
            default: value = $urandom_range(0, 32768);
         endcase
         write_reg(CFG_AMPLITUDE_GAIN, ($urandom & 32'hFFFF_0000) | value);
      end
      if (write_all || $urandom_range(0, 1) == 0) begin
         write_reg(CFG_RESOLUTION_MODE, ($urandom & 32'hFFFF_FFFC) | $urandom_range(0, 3));
      end
      if (write_all || $urandom_range(0, 1) == 0) begin
         value = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
         write_reg(CFG_CHANNEL_COUNT, ($urandom & 32'hFFFF_FFF0) | value);
      end
      if (write_all || $urandom_range(0, 1) == 0) begin
         write_reg(CFG_SWEEP_ENABLE, $urandom);
      end
      if (write_all || $urandom_range(0, 1) == 0) begin
         case ($urandom_range(0, 7))
            0: value = 32'd0;
            1: value = 32'hFFFF_FFFF;
            2: value = $urandom;
            default: value = RATIO_UNITY + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
         endcase
         write_reg(CFG_SWEEP_RATIO, value);
      end
   endtask

   initial begin : stimulus
      int frames_sent;
      int segment;
      int seg_len;
      logic frame_bit;
      frames_sent = 0;
      segment     = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: zero step, two channels, 16 bit; an empty request in between.
      send_frame(1'b1);
      send_frame(1'b0);
      send_frame(1'b1);

      // Quarter-turn step visits all four quadrants, mirrored and negated.
      wait_idle();
      write_reg(CFG_PHASE_STEP, 32'h4000_0000);
      write_reg(CFG_CHANNEL_COUNT, 32'd1);
      repeat (4) send_frame(1'b1);

      wait_idle();
      write_reg(CFG_RESOLUTION_MODE, {30'd0, RES_24});
      write_reg(CFG_CHANNEL_COUNT, 32'd0);
      repeat (2) send_frame(1'b1);

      // Gain above full scale at 32 bit saturates on both signs.
      wait_idle();
      write_reg(CFG_RESOLUTION_MODE, {30'd0, RES_32});
      write_reg(CFG_AMPLITUDE_GAIN, 32'd65535);
      write_reg(CFG_CHANNEL_COUNT, 32'd8);
      repeat (4) send_frame(1'b1);

      wait_idle();
      write_reg(CFG_RESOLUTION_MODE, {30'd0, RES_UNUSED});
      write_reg(CFG_AMPLITUDE_GAIN, 32'd0);
      write_reg(CFG_CHANNEL_COUNT, 32'd15);
      write_reg(CFG_SPARE_LOW, 32'hFFFF_FFFF);
      write_reg(CFG_SPARE_HIGH, 32'h1234_5678);
      repeat (2) send_frame(1'b1);

      // Largest step with the largest ratio drives the swept step into saturation.
      wait_idle();
      write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
      write_reg(CFG_AMPLITUDE_GAIN, GAIN_UNITY);
      write_reg(CFG_CHANNEL_COUNT, 32'd9);
      write_reg(CFG_SWEEP_ENABLE, 32'd1);
      write_reg(CFG_SWEEP_RATIO, 32'hFFFF_FFFF);
      repeat (3) send_frame(1'b1);

      wait_idle();
      write_reg(CFG_SWEEP_RATIO, 32'd0);
      repeat (3) send_frame(1'b1);

      // Zero step with sweep on keeps the tone frozen.
      wait_idle();
      write_reg(CFG_PHASE_STEP, 32'd0);
      write_reg(CFG_SWEEP_RATIO, RATIO_UNITY);
      repeat (2) send_frame(1'b1);

      while (frames_sent < RANDOM_FRAMES) begin
         wait_idle();
         shuffle_settings(segment == 0);
         seg_len     = $urandom_range(8, 30);
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
         rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
         if (segment == 2) begin
            req_gap_max     = 0;
            rsp_hold_cycles = HOLD_CYCLES;
         end
         repeat (seg_len) begin
            frame_bit = ($urandom_range(0, 9) != 0);
            send_frame(frame_bit);
            if (frame_bit) begin
               frames_sent++;
            end
         end
         segment++;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && expected_left == 0) begin
         $display("tb_sine_tone_sweep_generator OK");
      end else begin
         $display("tb_sine_tone_sweep_generator NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
